[src/sbap_pkg.sv]
package sbap_pkg;

    localparam int IMG_WIDTH  = 64;
    localparam int IMG_HEIGHT = 64;
    localparam int MAX_RUNS   = 32;

    localparam int CFG_W  = 7;
    localparam int X_W    = $clog2(IMG_WIDTH);
    localparam int XC_W   = $clog2(IMG_WIDTH + 1);
    localparam int Y_W    = $clog2(IMG_HEIGHT);
    localparam int YC_W   = $clog2(IMG_HEIGHT + 1);
    localparam int RUN_IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int RUN_CW = $clog2(MAX_RUNS + 1);
    localparam int CCNT_W = (XC_W > CFG_W) ? XC_W : CFG_W;
    localparam int RCNT_W = (YC_W > CFG_W) ? YC_W : CFG_W;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_COL_START = 2'd0;
    localparam logic [1:0] REG_COL_END   = 2'd1;
    localparam logic [1:0] REG_ROW_START = 2'd2;
    localparam logic [1:0] REG_ROW_END   = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] col_start;
        logic [CFG_W-1:0] col_end;
        logic [CFG_W-1:0] row_start;
        logic [CFG_W-1:0] row_end;
    } cfg_t;

    typedef struct packed {
        logic [5:0] rect_x;
        logic [5:0] rect_y;
        logic [6:0] rect_width;
        logic [6:0] rect_height;
        logic       found;
        logic       last_rect;
        logic       overflow;
    } result_t;

endpackage

[src/sbap_ram.sv]
module sbap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/sbap_cfg.sv]
module sbap_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbap_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbap_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbap_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output sbap_pkg::cfg_t                cfg
);

    sbap_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.col_start <= sbap_pkg::CFG_W'(0);
            cfg_reg.col_end   <= sbap_pkg::CFG_W'(64);
            cfg_reg.row_start <= sbap_pkg::CFG_W'(0);
            cfg_reg.row_end   <= sbap_pkg::CFG_W'(64);
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                sbap_pkg::REG_COL_START: cfg_reg.col_start <= pwdata[sbap_pkg::CFG_W-1:0];
                sbap_pkg::REG_COL_END:   cfg_reg.col_end   <= pwdata[sbap_pkg::CFG_W-1:0];
                sbap_pkg::REG_ROW_START: cfg_reg.row_start <= pwdata[sbap_pkg::CFG_W-1:0];
                sbap_pkg::REG_ROW_END:   cfg_reg.row_end   <= pwdata[sbap_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            sbap_pkg::REG_COL_START: prdata = sbap_pkg::PDATA_W'(cfg_reg.col_start);
            sbap_pkg::REG_COL_END:   prdata = sbap_pkg::PDATA_W'(cfg_reg.col_end);
            sbap_pkg::REG_ROW_START: prdata = sbap_pkg::PDATA_W'(cfg_reg.row_start);
            sbap_pkg::REG_ROW_END:   prdata = sbap_pkg::PDATA_W'(cfg_reg.row_end);
            default:                 prdata = '0;
        endcase
    end

endmodule

[src/sbap_seq.sv]
module sbap_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbap_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    input  logic [7:0]                       alpha,
    output logic                             in_stall,
    output logic                             ram_we,
    output logic [sbap_pkg::Y_W-1:0]         ram_waddr,
    output logic [sbap_pkg::IMG_WIDTH-1:0]   ram_wdata,
    output logic [sbap_pkg::Y_W-1:0]         ram_raddr,
    input  logic [sbap_pkg::IMG_WIDTH-1:0]   ram_rdata,
    input  logic                             out_free,
    output logic                             emit,
    output sbap_pkg::result_t                res
);

    localparam int X_W    = sbap_pkg::X_W;
    localparam int XC_W   = sbap_pkg::XC_W;
    localparam int Y_W    = sbap_pkg::Y_W;
    localparam int YC_W   = sbap_pkg::YC_W;
    localparam int RUN_IW = sbap_pkg::RUN_IW;
    localparam int RUN_CW = sbap_pkg::RUN_CW;
    localparam int CCNT_W = sbap_pkg::CCNT_W;
    localparam int RCNT_W = sbap_pkg::RCNT_W;
    localparam int IW     = sbap_pkg::IMG_WIDTH;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_COLACC  = 3'd1;
    localparam logic [2:0] S_COLSCAN = 3'd2;
    localparam logic [2:0] S_MASK    = 3'd3;
    localparam logic [2:0] S_ROWSCAN = 3'd4;
    localparam logic [2:0] S_EMIT    = 3'd5;
    localparam logic [2:0] S_EMPTY   = 3'd6;

    logic [2:0]        state_reg,   state_next;
    logic [X_W-1:0]    col_reg,     col_next;
    logic [Y_W-1:0]    row_reg,     row_next;
    logic [IW-1:0]     rowbuf_reg,  rowbuf_next;
    logic [RCNT_W-1:0] h_reg,       h_next;
    logic              pend_reg,    pend_next;
    logic [Y_W-1:0]    hd_reg,      hd_next;
    logic [IW-1:0]     colany_reg,  colany_next;
    logic [CCNT_W-1:0] c_reg,       c_next;
    logic              open_reg,    open_next;
    logic [X_W-1:0]    left_reg,    left_next;
    logic              over_reg,    over_next;
    logic [RUN_CW-1:0] rcount_reg,  rcount_next;
    logic [RUN_CW-1:0] k_reg,       k_next;
    logic [IW-1:0]     mask_reg,    mask_next;
    logic              seen_reg,    seen_next;
    logic [Y_W-1:0]    y_reg,       y_next;
    logic [YC_W-1:0]   height_reg,  height_next;

    logic [X_W-1:0]    run_left_reg  [sbap_pkg::MAX_RUNS];
    logic [XC_W-1:0]   run_width_reg [sbap_pkg::MAX_RUNS];

    logic [XC_W-1:0]   cend;
    logic [YC_W-1:0]   rend;
    logic              accept;
    logic              occ;
    logic              col_last;
    logic              row_last;
    logic              issue;
    logic              col_in_range;
    logic              col_hit;
    logic              row_hit;
    logic              seen_eff;
    logic [Y_W-1:0]    y_eff;
    logic              run_wr;
    logic [X_W-1:0]    cur_left;
    logic [XC_W-1:0]   cur_width;
    logic [XC_W:0]     cur_right;
    logic              last_run;
    logic [IW-1:0]     mask_calc;

    // End bounds past the image are clamped to its edge.
    assign cend = (32'(cfg.col_end) > sbap_pkg::IMG_WIDTH)
                  ? XC_W'(sbap_pkg::IMG_WIDTH) : XC_W'(cfg.col_end);
    assign rend = (32'(cfg.row_end) > sbap_pkg::IMG_HEIGHT)
                  ? YC_W'(sbap_pkg::IMG_HEIGHT) : YC_W'(cfg.row_end);

    assign in_stall = (state_reg != S_LOAD);
    assign accept   = in_valid && (state_reg == S_LOAD);
    assign occ      = (alpha != 8'd0);
    assign col_last = (col_reg == X_W'(sbap_pkg::IMG_WIDTH - 1));
    assign row_last = (row_reg == Y_W'(sbap_pkg::IMG_HEIGHT - 1));

    always_comb
    begin
        ram_wdata          = rowbuf_reg;
        ram_wdata[col_reg] = occ;
    end

    assign ram_we    = accept && col_last;
    assign ram_waddr = row_reg;
    assign ram_raddr = h_reg[Y_W-1:0];

    assign issue        = (h_reg < RCNT_W'(rend));
    assign col_in_range = (c_reg < CCNT_W'(cend));
    assign col_hit      = colany_reg[c_reg[X_W-1:0]];

    assign cur_left  = run_left_reg[k_reg[RUN_IW-1:0]];
    assign cur_width = run_width_reg[k_reg[RUN_IW-1:0]];
    assign cur_right = (XC_W + 1)'(cur_left) + (XC_W + 1)'(cur_width);
    assign last_run  = (RUN_CW'(k_reg + 1'b1) == rcount_reg);

    // Column mask of the current run: bits left up to left+width-1.
    always_comb
    begin
        for (int i = 0; i < IW; i++)
        begin
            mask_calc[i] = ((XC_W + 1)'(i) >= (XC_W + 1)'(cur_left)) &&
                           ((XC_W + 1)'(i) < cur_right);
        end
    end

    assign row_hit  = |(ram_rdata & mask_reg);
    assign seen_eff = seen_reg || row_hit;
    assign y_eff    = (seen_reg || !row_hit) ? y_reg : hd_reg;

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        rowbuf_next = rowbuf_reg;
        h_next      = h_reg;
        pend_next   = pend_reg;
        hd_next     = hd_reg;
        colany_next = colany_reg;
        c_next      = c_reg;
        open_next   = open_reg;
        left_next   = left_reg;
        over_next   = over_reg;
        rcount_next = rcount_reg;
        k_next      = k_reg;
        mask_next   = mask_reg;
        seen_next   = seen_reg;
        y_next      = y_reg;
        height_next = height_reg;
        run_wr      = 1'b0;
        emit        = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    rowbuf_next = ram_wdata;
                    if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_last ? '0 : Y_W'(row_reg + 1'b1);
                    end
                    else
                    begin
                        col_next = X_W'(col_reg + 1'b1);
                    end
                    if (col_last && row_last)
                    begin
                        state_next  = S_COLACC;
                        h_next      = '0;
                        pend_next   = 1'b0;
                        colany_next = '0;
                        c_next      = CCNT_W'(cfg.col_start);
                        open_next   = 1'b0;
                        over_next   = 1'b0;
                        rcount_next = '0;
                    end
                end
            end

            // One row word per cycle is ORed into the column occupancy vector.
            S_COLACC:
            begin
                pend_next = issue;
                if (issue)
                begin
                    h_next = RCNT_W'(h_reg + 1'b1);
                end
                if (pend_reg)
                begin
                    colany_next = colany_reg | ram_rdata;
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_COLSCAN;
                end
            end

            S_COLSCAN:
            begin
                if (col_in_range)
                begin
                    c_next = CCNT_W'(c_reg + 1'b1);
                    if (col_hit && !open_reg)
                    begin
                        left_next = c_reg[X_W-1:0];
                        open_next = 1'b1;
                    end
                    else if (!col_hit && open_reg)
                    begin
                        if (rcount_reg < RUN_CW'(sbap_pkg::MAX_RUNS))
                        begin
                            run_wr      = 1'b1;
                            rcount_next = RUN_CW'(rcount_reg + 1'b1);
                        end
                        else
                        begin
                            over_next = 1'b1;
                        end
                        open_next = 1'b0;
                    end
                end
                else if (rcount_reg == '0)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_MASK;
                end
            end

            S_MASK:
            begin
                mask_next   = mask_calc;
                h_next      = RCNT_W'(cfg.row_start);
                pend_next   = 1'b0;
                seen_next   = 1'b0;
                y_next      = '0;
                height_next = '0;
                state_next  = S_ROWSCAN;
            end

            // Reads run one row ahead; a read in flight when the run closes is dropped.
            S_ROWSCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    h_next  = RCNT_W'(h_reg + 1'b1);
                    hd_next = h_reg[Y_W-1:0];
                end
                if (pend_reg)
                begin
                    seen_next = seen_eff;
                    y_next    = y_eff;
                    if (seen_eff && !row_hit)
                    begin
                        height_next = YC_W'(hd_reg) - YC_W'(y_eff);
                        state_next  = S_EMIT;
                    end
                    else if (seen_eff && (hd_reg == Y_W'(sbap_pkg::IMG_HEIGHT - 1)))
                    begin
                        height_next = YC_W'(YC_W'(hd_reg) - YC_W'(y_eff) + 1'b1);
                        state_next  = S_EMIT;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    k_next     = RUN_CW'(k_reg + 1'b1);
                    state_next = last_run ? S_LOAD : S_MASK;
                end
            end

            S_EMPTY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        if (state_reg == S_EMPTY)
        begin
            res.last_rect = 1'b1;
        end
        else
        begin
            res.rect_x      = 6'(cur_left);
            res.rect_y      = 6'(y_reg);
            res.rect_width  = 7'(cur_width);
            res.rect_height = 7'(height_reg);
            res.found       = 1'b1;
            res.last_rect   = last_run;
            res.overflow    = over_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            col_reg    <= '0;
            row_reg    <= '0;
            h_reg      <= '0;
            pend_reg   <= 1'b0;
            c_reg      <= '0;
            open_reg   <= 1'b0;
            over_reg   <= 1'b0;
            rcount_reg <= '0;
            k_reg      <= '0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            h_reg      <= h_next;
            pend_reg   <= pend_next;
            c_reg      <= c_next;
            open_reg   <= open_next;
            over_reg   <= over_next;
            rcount_reg <= rcount_next;
            k_reg      <= k_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rowbuf_reg <= rowbuf_next;
        hd_reg     <= hd_next;
        colany_reg <= colany_next;
        left_reg   <= left_next;
        mask_reg   <= mask_next;
        y_reg      <= y_next;
        height_reg <= height_next;
        if (run_wr)
        begin
            run_left_reg[rcount_reg[RUN_IW-1:0]]  <= left_reg;
            run_width_reg[rcount_reg[RUN_IW-1:0]] <= XC_W'(c_reg) - XC_W'(left_reg);
        end
    end

endmodule

[src/sprite_bounds_by_alpha_projection_unit.sv]
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// in       | in        | in_valid / in_stall  | alpha
// out      | out       | out_valid / out_stall| rect_x rect_y rect_width rect_height
//          |           |                     | found last_rect overflow
// config   | in        | APB psel/penable    | paddr pwdata prdata pready
//
// Pixels are taken one beat per cycle while in_stall is low; each full row is written to the
// row memory as one word. After the last pixel the block stalls its input while it ORs the rows
// into the column vector and scans the columns; then, per run, it builds the column mask, reads
// the rows on the memory read port and hands the rectangle over.
// Reset clears the sequencer, its counters and out_valid and sets the bounds to the full image;
// the row memory needs no clearing pass.
// A stalled result holds in the output register while the next frame is already loading.
module sprite_bounds_by_alpha_projection_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    alpha,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [5:0]                    rect_x,
    output logic [5:0]                    rect_y,
    output logic [6:0]                    rect_width,
    output logic [6:0]                    rect_height,
    output logic                          found,
    output logic                          last_rect,
    output logic                          overflow,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbap_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbap_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbap_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    sbap_pkg::cfg_t                       cfg;
    sbap_pkg::result_t                    res;
    sbap_pkg::result_t                    res_reg;
    logic                                 out_valid_reg;
    logic                                 out_free;
    logic                                 emit;
    logic                                 ram_we;
    logic [sbap_pkg::Y_W-1:0]             ram_waddr;
    logic [sbap_pkg::IMG_WIDTH-1:0]       ram_wdata;
    logic [sbap_pkg::Y_W-1:0]             ram_raddr;
    logic [sbap_pkg::IMG_WIDTH-1:0]       ram_rdata;

    sbap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sbap_ram #(
        .WIDTH (sbap_pkg::IMG_WIDTH),
        .DEPTH (sbap_pkg::IMG_HEIGHT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sbap_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .alpha     (alpha),
        .in_stall  (in_stall),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .emit      (emit),
        .res       (res)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rect_x      = res_reg.rect_x;
    assign rect_y      = res_reg.rect_y;
    assign rect_width  = res_reg.rect_width;
    assign rect_height = res_reg.rect_height;
    assign found       = res_reg.found;
    assign last_rect   = res_reg.last_rect;
    assign overflow    = res_reg.overflow;

endmodule

[src/sbap_chk.sv]
module sbap_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [5:0]                    rect_x,
    input logic [5:0]                    rect_y,
    input logic [6:0]                    rect_width,
    input logic [6:0]                    rect_height,
    input logic                          found,
    input logic                          last_rect,
    input logic                          overflow
);

    // A stalled result beat must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rect_x) && $stable(rect_y) &&
            $stable(rect_width) && $stable(rect_height) && $stable(found) &&
            $stable(last_rect) && $stable(overflow))
        else $error("stalled result beat changed");

    // The empty-frame beat closes the frame and carries no rectangle.
    a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> last_rect && rect_x == 6'd0 && rect_y == 6'd0 &&
            rect_width == 7'd0 && rect_height == 7'd0 && !overflow)
        else $error("malformed empty-frame beat");

    // A rectangle has columns and lies inside the image width.
    a_rect_cols: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> rect_width != 7'd0 &&
            (8'(rect_x) + 8'(rect_width) <= 8'(sbap_pkg::IMG_WIDTH)))
        else $error("rectangle columns out of range");

    // A closed rectangle lies inside the image height.
    a_rect_rows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found && rect_height != 7'd0 |->
            (8'(rect_y) + 8'(rect_height) <= 8'(sbap_pkg::IMG_HEIGHT)))
        else $error("rectangle rows out of range");

endmodule

bind sprite_bounds_by_alpha_projection_unit sbap_chk u_sbap_chk (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import sbap_pkg::*;

    localparam int NPIX        = IMG_WIDTH * IMG_HEIGHT;
    localparam int CYCLE_LIMIT = 4_000_000;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} rx_pattern_e;

    // Keeps its own copy of the frame and the bounds registers, and works out the
    // rectangles that each completed frame should produce.
    class rect_ledger;
        bit      occ [NPIX];
        int      pos;
        cfg_t    cfg;
        result_t pending_rects [$];
        int      errors;
        int      seen_rects;

        function new();
            pos           = 0;
            errors        = 0;
            seen_rects    = 0;
            cfg.col_start = '0;
            cfg.col_end   = CFG_W'(IMG_WIDTH);
            cfg.row_start = '0;
            cfg.row_end   = CFG_W'(IMG_HEIGHT);
        endfunction

        function void take_pixel(input logic [7:0] a);
            int      cend;
            int      rend;
            int      left;
            int      nrun;
            int      y;
            int      ht;
            int      c;
            int      h;
            int      k;
            bit      open;
            bit      over;
            bit      any;
            bit      seen;
            int      run_x [MAX_RUNS];
            int      run_w [MAX_RUNS];
            result_t r;

            occ[pos] = (a != 8'd0);
            if (pos < NPIX - 1) begin
                pos++;
                return;
            end
            pos  = 0;
            cend = (cfg.col_end > IMG_WIDTH) ? IMG_WIDTH : int'(cfg.col_end);
            rend = (cfg.row_end > IMG_HEIGHT) ? IMG_HEIGHT : int'(cfg.row_end);
            nrun = 0;
            left = 0;
            open = 1'b0;
            over = 1'b0;

            // Column pass: a run closes at the first empty column; one still open at
            // the right edge of the scan is lost.
            for (c = int'(cfg.col_start); c < cend; c++) begin
                any = 1'b0;
                for (h = 0; h < rend; h++)
                    any |= occ[h * IMG_WIDTH + c];
                if (any && !open) begin
                    left = c;
                    open = 1'b1;
                end else if (!any && open) begin
                    if (nrun < MAX_RUNS) begin
                        run_x[nrun] = left;
                        run_w[nrun] = c - left;
                        nrun++;
                    end else begin
                        over = 1'b1;
                    end
                    open = 1'b0;
                end
            end

            if (nrun == 0) begin
                r           = '0;
                r.last_rect = 1'b1;
                pending_rects.push_back(r);
                return;
            end

            for (k = 0; k < nrun; k++) begin
                y    = 0;
                ht   = 0;
                seen = 1'b0;
                for (h = int'(cfg.row_start); h < rend; h++) begin
                    any = 1'b0;
                    for (c = run_x[k]; c < run_x[k] + run_w[k]; c++)
                        any |= occ[h * IMG_WIDTH + c];
                    if (any && !seen) begin
                        y    = h;
                        seen = 1'b1;
                    end
                    if (seen && !any) begin
                        ht = h - y;
                        break;
                    end
                    // The bottom row of the image closes a run and counts in its height.
                    if (seen && h == IMG_HEIGHT - 1) begin
                        ht = h - y + 1;
                        break;
                    end
                end
                r.rect_x      = 6'(run_x[k]);
                r.rect_y      = 6'(y);
                r.rect_width  = 7'(run_w[k]);
                r.rect_height = 7'(ht);
                r.found       = 1'b1;
                r.last_rect   = (k == nrun - 1);
                r.overflow    = over;
                pending_rects.push_back(r);
            end
        endfunction

        function void compare_field(input string name, input logic [6:0] want,
                                    input logic [6:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_rect(input result_t got);
            result_t want;

            seen_rects++;
            if (pending_rects.size() == 0) begin
                $display("%0t: result beat %h with nothing expected", $time, got);
                errors++;
                return;
            end
            want = pending_rects.pop_front();
            compare_field("rect_x", 7'(want.rect_x), 7'(got.rect_x));
            compare_field("rect_y", 7'(want.rect_y), 7'(got.rect_y));
            compare_field("rect_width", want.rect_width, got.rect_width);
            compare_field("rect_height", want.rect_height, got.rect_height);
            compare_field("found", 7'(want.found), 7'(got.found));
            compare_field("last_rect", 7'(want.last_rect), 7'(got.last_rect));
            compare_field("overflow", 7'(want.overflow), 7'(got.overflow));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [7:0]          alpha;
    logic                out_valid;
    logic                out_stall;
    logic [5:0]          rect_x;
    logic [5:0]          rect_y;
    logic [6:0]          rect_width;
    logic [6:0]          rect_height;
    logic                found;
    logic                last_rect;
    logic                overflow;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    rect_ledger  sb;
    bit          canvas [NPIX];
    int          burst_left;
    int          gap_max;
    int          rx_hold_cycles;
    rx_pattern_e rx_mode;
    longint      cycle_count = 0;

    sprite_bounds_by_alpha_projection_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .alpha       (alpha),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .found       (found),
        .last_rect   (last_rect),
        .overflow    (overflow),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.take_pixel(alpha);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_rect({rect_x, rect_y, rect_width, rect_height, found, last_rect,
                           overflow});
    end

    // Receiver: its own stall pattern, changing now and then, plus a long hold-off
    // when one is requested.
    initial
    begin
        out_stall = 1'b0;
        rx_mode   = RX_OPEN;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles--;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HALF:  out_stall <= $urandom_range(0, 1);
                    default:  out_stall <= ($urandom_range(0, 7) < 6);
                endcase
            end
            if ($urandom_range(0, 199) == 0)
                rx_mode = rx_pattern_e'($urandom_range(0, 3));
        end
    end

    task automatic send_pixel(input logic [7:0] a);
        int gap;

        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 300);
        end
        burst_left--;
        in_valid <= 1'b1;
        alpha    <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        logic [7:0] a;

        for (int i = 0; i < NPIX; i++)
        begin
            if (!canvas[i])
                a = 8'd0;
            else
                case ($urandom_range(0, 3))
                    0:       a = 8'hFF;
                    1:       a = 8'h01;
                    default: a = 8'($urandom_range(1, 255));
                endcase
            send_pixel(a);
        end
    endtask

    task automatic clear_canvas();
        foreach (canvas[i]) canvas[i] = 1'b0;
    endtask

    task automatic paint_box(input int x, input int y, input int w, input int h);
        for (int r = y; r < y + h && r < IMG_HEIGHT; r++)
            for (int c = x; c < x + w && c < IMG_WIDTH; c++)
                canvas[r * IMG_WIDTH + c] = 1'b1;
    endtask

    task automatic paint_stripes(input int pitch);
        for (int c = 0; c < IMG_WIDTH; c += pitch)
            paint_box(c, 0, 1, IMG_HEIGHT);
    endtask

    task automatic paint_sprites(input int count, input int max_w, input int max_h);
        repeat (count)
            paint_box($urandom_range(0, IMG_WIDTH - 1), $urandom_range(0, IMG_HEIGHT - 1),
                      $urandom_range(1, max_w), $urandom_range(1, max_h));
    endtask

    // Lowers valid and waits until every expected rectangle has been handed over.
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        while (sb.pending_rects.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
        logic [PDATA_W-1:0] junk;

        junk = $urandom;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[PDATA_W-1:CFG_W], v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[CFG_W-1:0] !== v)
        begin
            $display("%0t: register %0d read back %0d, expected %0d", $time, idx,
                     prdata[CFG_W-1:0], v);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COL_START: sb.cfg.col_start = v;
            REG_COL_END:   sb.cfg.col_end   = v;
            REG_ROW_START: sb.cfg.row_start = v;
            default:       sb.cfg.row_end   = v;
        endcase
    endtask

    task automatic set_bounds(input int cs, input int ce, input int rs, input int re);
        drain(8);
        write_reg(REG_COL_START, CFG_W'(cs));
        write_reg(REG_COL_END, CFG_W'(ce));
        write_reg(REG_ROW_START, CFG_W'(rs));
        write_reg(REG_ROW_END, CFG_W'(re));
    endtask

    // Mostly useful bounds, with the register extremes mixed in.
    function automatic int pick_bound(input int lo, input int hi);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return IMG_WIDTH;
            2:       return (1 << CFG_W) - 1;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    initial
    begin
        int frame_no;
        int rects_before;

        sb             = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        alpha          = 8'd0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        burst_left     = 0;
        gap_max        = 0;
        rx_hold_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Blank frame, then a full frame whose only run stays open at the right edge.
        clear_canvas();
        send_frame();
        gap_max = 4;
        paint_box(0, 0, IMG_WIDTH, IMG_HEIGHT);
        send_frame();

        // Thirty-two single-column runs, each closed by the bottom row.
        clear_canvas();
        paint_stripes(2);
        send_frame();

        // Left edge, bottom edge, a split run and a run open at the right edge.
        gap_max = 0;
        clear_canvas();
        paint_box(0, 0, 3, 5);
        paint_box(10, 60, 4, 4);
        paint_box(20, 10, 1, 1);
        paint_box(30, 5, 2, 3);
        paint_box(30, 20, 2, 3);
        paint_box(62, 12, 2, 6);
        send_frame();

        // A window: runs cut by its edges and a run still open at its lower bound.
        set_bounds(10, 50, 5, 40);
        gap_max = 12;
        clear_canvas();
        paint_box(5, 10, 10, 5);
        paint_box(45, 30, 10, 20);
        paint_box(20, 30, 3, 20);
        paint_box(25, 0, 2, 8);
        paint_box(35, 45, 2, 5);
        paint_box(40, 38, 2, 2);
        send_frame();

        // Bounds past the image are clamped; a row pass that scans nothing.
        set_bounds(0, 127, 64, 127);
        clear_canvas();
        paint_sprites(12, 5, 20);
        send_frame();

        // Start past the end, and then a reversed range on both axes.
        set_bounds(127, 64, 0, 64);
        send_frame();
        set_bounds(40, 20, 127, 0);
        gap_max = 3;
        send_frame();

        // Row pass over the bottom row alone.
        set_bounds(0, 64, 63, 64);
        clear_canvas();
        paint_stripes(3);
        send_frame();

        // Long hold-off at the receiver while two frames go in back to back, so that
        // the block has to stall its input.
        set_bounds(0, 64, 0, 64);
        gap_max        = 0;
        rx_hold_cycles = 12000;
        clear_canvas();
        paint_stripes(2);
        send_frame();
        clear_canvas();
        paint_sprites(20, 4, 12);
        send_frame();
        drain(8);

        frame_no     = 0;
        rects_before = sb.seen_rects;
        while ((sb.seen_rects - rects_before < 60 || frame_no < 10) && frame_no < 40)
        begin
            if ($urandom_range(0, 2) == 0)
                set_bounds(pick_bound(0, 20), pick_bound(40, 64), pick_bound(0, 20),
                           pick_bound(30, 64));
            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            clear_canvas();
            case ($urandom_range(0, 5))
                0, 1: paint_sprites($urandom_range(1, 40), 6, 30);
                2:    paint_sprites($urandom_range(1, 6), 20, IMG_HEIGHT);
                3:
                begin
                    paint_stripes($urandom_range(2, 5));
                    paint_sprites($urandom_range(0, 4), 8, 8);
                end
                4:
                begin
                    foreach (canvas[i])
                        if ($urandom_range(0, 999) < 3)
                            canvas[i] = 1'b1;
                end
                default:
                begin
                    paint_sprites($urandom_range(1, 15), 10, 40);
                    foreach (canvas[i])
                        if ($urandom_range(0, 999) == 0)
                            canvas[i] = 1'b1;
                end
            endcase
            send_frame();
            frame_no++;
        end

        drain(200);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
